/* hdl/b64_pkg.sv */
// Shared types, constants and alphabet functions of the Base64 stream codec.
package b64_pkg;

    localparam int unsigned MAX_RESULTS = 4;
    localparam int unsigned CNT_W = $clog2(MAX_RESULTS + 1);

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_CHAR   = 2'd1,
        ST_BAD_LENGTH = 2'd2,
        ST_BAD_PAD    = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0] pos;
        logic [5:0] held;
        logic [1:0] pad;
        t_status    err;
    } t_state;

    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       last;
        t_status    status;
    } t_result;

    // Maps a six-bit value to its alphabet character.
    function automatic logic [7:0] enc_char(input logic [5:0] v);
        logic [7:0] w;
        begin
            w = {2'b00, v};
            if (v < 6'd26) begin
                enc_char = 8'h41 + w;
            end else if (v < 6'd52) begin
                enc_char = 8'h61 + w - 8'd26;
            end else if (v < 6'd62) begin
                enc_char = 8'h30 + w - 8'd52;
            end else if (v == 6'd62) begin
                enc_char = 8'h2B;
            end else begin
                enc_char = 8'h2F;
            end
        end
    endfunction

    // Returns {invalid, value} for one character.
    function automatic logic [6:0] sym_value(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'h00;
            sym_value = 7'h40;
            if (c >= 8'h41 && c <= 8'h5A) begin
                d = c - 8'h41;
                sym_value = {1'b0, d[5:0]};
            end else if (c >= 8'h61 && c <= 8'h7A) begin
                d = c - 8'h61 + 8'd26;
                sym_value = {1'b0, d[5:0]};
            end else if (c >= 8'h30 && c <= 8'h39) begin
                d = c - 8'h30 + 8'd52;
                sym_value = {1'b0, d[5:0]};
            end else if (c == 8'h2B) begin
                sym_value = 7'd62;
            end else if (c == 8'h2F) begin
                sym_value = 7'd63;
            end
        end
    endfunction

endpackage

/* hdl/b64_in_if.sv */
// Input channel of the Base64 stream codec: one byte or character per transfer.
interface b64_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       is_last;

    modport source (output valid, output in_byte, output is_last, input ready);
    modport sink (input valid, input in_byte, input is_last, output ready);
endinterface

/* hdl/b64_out_if.sv */
// Output channel of the Base64 stream codec: one result per transfer.
interface b64_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       last_of_stream;
    logic [1:0] status;

    modport source (output valid, output out_byte, output has_byte,
                    output last_of_stream, output status, input ready);
    modport sink (input valid, input out_byte, input has_byte,
                  input last_of_stream, input status, output ready);
endinterface

/* hdl/b64_core.sv */
// Combinational encode and decode step: next stream state and up to four results.
module b64_core (
    input  logic                        i_mode,
    input  b64_pkg::t_state             i_state,
    input  logic [7:0]                  i_byte,
    input  logic                        i_last,
    output b64_pkg::t_state             o_state,
    output b64_pkg::t_result            o_res [b64_pkg::MAX_RESULTS],
    output logic [b64_pkg::CNT_W-1:0]   o_cnt
);
    import b64_pkg::*;

    logic [7:0]       ch [MAX_RESULTS];
    logic [CNT_W-1:0] n;
    t_state           nst;
    logic [6:0]       sv;
    t_status          err;
    logic [7:0]       dbyte;
    logic             dhas;

    always_comb begin
        nst   = i_state;
        n     = '0;
        err   = i_state.err;
        dbyte = 8'h00;
        dhas  = 1'b0;
        sv    = sym_value(i_byte);
        for (int k = 0; k < MAX_RESULTS; k++) begin
            ch[k] = 8'h00;
        end
        for (int k = 0; k < MAX_RESULTS; k++) begin
            o_res[k] = '0;
        end

        if (i_mode == MODE_ENCODE) begin
            case (i_state.pos)
                2'd1: begin
                    ch[0]    = enc_char({i_state.held[1:0], i_byte[7:4]});
                    nst.held = {2'b00, i_byte[3:0]};
                    nst.pos  = 2'd2;
                    n        = CNT_W'(1);
                    if (i_last) begin
                        ch[1] = enc_char({i_byte[3:0], 2'b00});
                        ch[2] = PAD_CHAR;
                        n     = CNT_W'(3);
                    end
                end
                2'd2: begin
                    ch[0]    = enc_char({i_state.held[3:0], i_byte[7:6]});
                    ch[1]    = enc_char(i_byte[5:0]);
                    nst.held = '0;
                    nst.pos  = 2'd0;
                    n        = CNT_W'(2);
                end
                default: begin
                    ch[0]    = enc_char(i_byte[7:2]);
                    nst.held = {4'b0000, i_byte[1:0]};
                    nst.pos  = 2'd1;
                    n        = CNT_W'(1);
                    if (i_last) begin
                        ch[1] = enc_char({i_byte[1:0], 4'b0000});
                        ch[2] = PAD_CHAR;
                        ch[3] = PAD_CHAR;
                        n     = CNT_W'(4);
                    end
                end
            endcase
            for (int k = 0; k < MAX_RESULTS; k++) begin
                o_res[k].data   = ch[k];
                o_res[k].has    = 1'b1;
                o_res[k].last   = i_last && (CNT_W'(k + 1) == n);
                o_res[k].status = ST_OK;
            end
        end else begin
            if (err == ST_OK) begin
                if (i_byte == PAD_CHAR) begin
                    if (i_state.pos < 2'd2) begin
                        err = ST_BAD_CHAR;
                    end else if (i_state.pos == 2'd2) begin
                        if (i_state.pad != 2'd0) begin
                            err = ST_BAD_CHAR;
                        end else if (i_state.held[3:0] != 4'd0) begin
                            err = ST_BAD_PAD;
                        end else begin
                            nst.pad = 2'd1;
                        end
                    end else begin
                        if (i_state.pad == 2'd0 && i_state.held[1:0] != 2'd0) begin
                            err = ST_BAD_PAD;
                        end else begin
                            nst.pad = i_state.pad + 2'd1;
                        end
                    end
                end else if (sv[6] || i_state.pad != 2'd0) begin
                    err = ST_BAD_CHAR;
                end else begin
                    case (i_state.pos)
                        2'd0: begin
                            nst.held = sv[5:0];
                        end
                        2'd1: begin
                            dbyte    = {i_state.held, sv[5:4]};
                            nst.held = {2'b00, sv[3:0]};
                            dhas     = 1'b1;
                        end
                        2'd2: begin
                            dbyte    = {i_state.held[3:0], sv[5:2]};
                            nst.held = {4'b0000, sv[1:0]};
                            dhas     = 1'b1;
                        end
                        default: begin
                            dbyte    = {i_state.held[1:0], sv[5:0]};
                            nst.held = '0;
                            dhas     = 1'b1;
                        end
                    endcase
                end
            end
            nst.pos = i_state.pos + 2'd1;
            if (i_last && err == ST_OK && i_state.pos != 2'd3) begin
                err = ST_BAD_LENGTH;
            end
            nst.err = err;
            o_res[0].data   = dhas ? dbyte : 8'h00;
            o_res[0].has    = dhas;
            o_res[0].last   = i_last;
            o_res[0].status = err;
            n = (dhas || i_last) ? CNT_W'(1) : CNT_W'(0);
        end

        if (i_last) begin
            nst = '0;
        end
        o_state = nst;
        o_cnt   = n;
    end

endmodule

/* hdl/base64_stream_codec_unit.sv */
// Top level of the Base64 stream codec: stream state, result queue and output register.
// The results of an item pass through the result queue and then the output register.
// Throughput: one result per cycle while the output is ready; a new input item is taken
// only once the queue is empty or its last result is moving to the output register,
// so the four-entry result queue drained into the output register paces the input.
// Reset is synchronous and clears the mode, the stream state, the queue and the output.
module base64_stream_codec_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    b64_in_if.sink      i_in,
    b64_out_if.source   o_out
);
    import b64_pkg::*;

    logic             r_mode;
    t_state           r_st;
    t_state           n_st;
    t_result          r_pend [MAX_RESULTS];
    logic [CNT_W-1:0] r_cnt;
    t_result          r_out;
    logic             r_out_valid;

    t_result          res [MAX_RESULTS];
    logic [CNT_W-1:0] res_cnt;
    logic             pend_valid;
    logic             out_free;
    logic             move;
    logic             in_fire;

    b64_core u_core (
        .i_mode  (r_mode),
        .i_state (r_st),
        .i_byte  (i_in.in_byte),
        .i_last  (i_in.is_last),
        .o_state (n_st),
        .o_res   (res),
        .o_cnt   (res_cnt)
    );

    assign pend_valid = (r_cnt != '0);
    assign out_free   = !r_out_valid || o_out.ready;
    assign move       = pend_valid && out_free;
    assign i_in.ready = (r_cnt == '0) || (r_cnt == CNT_W'(1) && move);
    assign in_fire    = i_in.valid && i_in.ready;

    assign o_out.valid          = r_out_valid;
    assign o_out.out_byte       = r_out.data;
    assign o_out.has_byte       = r_out.has;
    assign o_out.last_of_stream = r_out.last;
    assign o_out.status         = r_out.status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_ENCODE;
            r_st   <= '0;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
            r_st   <= '0;
        end else if (in_fire) begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (in_fire) begin
            r_cnt <= res_cnt;
        end else if (move) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_pend <= res;
        end else if (move) begin
            for (int k = 0; k < MAX_RESULTS - 1; k++) begin
                r_pend[k] <= r_pend[k + 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out <= r_pend[0];
        end
    end

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_RESULTS))
        else $error("result queue count out of range");

    a_status_only_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.has_byte) |-> o_out.last_of_stream)
        else $error("status-only result does not close the stream");

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in.is_last) |=> (r_cnt != '0))
        else $error("final element produced no result");
`endif

endmodule
